/* rtl/core/tss_pkg.sv */
package tss_pkg;

  localparam int unsigned SecondsWidth = 17;
  localparam int unsigned PosWidth     = 4;
  localparam int unsigned MaxLen       = 8;

  localparam logic [SecondsWidth-1:0] DaySeconds = 17'd86400;
  localparam logic [PosWidth-1:0]     PosMax     = 4'd9;
  localparam logic [PosWidth-1:0]     LenMax     = 4'd8;
  localparam logic [PosWidth-1:0]     LenHh      = 4'd2;
  localparam logic [PosWidth-1:0]     LenHhMm    = 4'd5;
  localparam logic [PosWidth-1:0]     LenHhMmSs  = 4'd8;
  localparam logic [PosWidth-1:0]     ColonPosA  = 4'd2;
  localparam logic [PosWidth-1:0]     ColonPosB  = 4'd5;

  localparam logic [7:0] CharColon = 8'h3a;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_LONG     = 3'd1,
    ST_NONDIGIT = 3'd2,
    ST_COLON    = 3'd3,
    ST_LENGTH   = 3'd4
  } status_t;

  typedef struct packed {
    logic [SecondsWidth-1:0] seconds;
    status_t                 status;
  } result_t;

  // Digit times positional weight, already reduced modulo one day.
  function automatic logic [SecondsWidth-1:0] digit_term(
    input logic [2:0] pos,
    input logic [3:0] digit
  );
    logic [SecondsWidth-1:0] term;
    term = '0;
    case (pos)
      3'd0: begin
        case (digit)
          4'd1:    term = 17'd36000;
          4'd2:    term = 17'd72000;
          4'd3:    term = 17'd21600;
          4'd4:    term = 17'd57600;
          4'd5:    term = 17'd7200;
          4'd6:    term = 17'd43200;
          4'd7:    term = 17'd79200;
          4'd8:    term = 17'd28800;
          4'd9:    term = 17'd64800;
          default: term = '0;
        endcase
      end
      3'd1:    term = SecondsWidth'(digit) * 17'd3600;
      3'd3:    term = SecondsWidth'(digit) * 17'd600;
      3'd4:    term = SecondsWidth'(digit) * 17'd60;
      3'd6:    term = SecondsWidth'(digit) * 17'd10;
      3'd7:    term = SecondsWidth'(digit);
      default: term = '0;
    endcase
    return term;
  endfunction

endpackage

/* rtl/core/tss_in_stage.sv */
module tss_in_stage import tss_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] character,
  input  logic       last,
  input  logic       advance,
  output logic       hold_valid,
  output logic [7:0] hold_char,
  output logic       hold_last
);

  logic accept;

  // Stall only while a held beat cannot move on this cycle.
  assign char_stall = hold_valid && !advance;
  assign accept     = char_valid && !char_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_char <= character;
      hold_last <= last;
    end
  end

endmodule

/* rtl/core/tss_scan.sv */
module tss_scan import tss_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  input  logic          advance,
  input  logic [7:0]    hold_char,
  input  logic          hold_last,
  output result_t       result
);

  logic                    accept_hours_only;
  logic [PosWidth-1:0]     position;
  logic [PosWidth-1:0]     position_next;
  logic [SecondsWidth-1:0] acc;
  logic [SecondsWidth-1:0] acc_next;
  status_t                 error_code;
  status_t                 error_code_next;

  logic                    in_range;
  logic                    colon_slot;
  logic                    is_colon;
  logic                    is_digit;
  status_t                 char_err;
  logic [SecondsWidth-1:0] term;
  logic [SecondsWidth:0]   sum;
  status_t                 final_status;

  always_comb begin
    in_range   = position < PosWidth'(MaxLen);
    colon_slot = (position == ColonPosA) || (position == ColonPosB);
    is_colon   = hold_char == CharColon;
    is_digit   = hold_char inside {[CharZero:CharNine]};
    term       = digit_term(position[2:0], 4'(hold_char - CharZero));

    char_err = ST_OK;
    if (!is_digit && !is_colon) begin
      char_err = ST_NONDIGIT;
    end else if (is_colon != colon_slot) begin
      char_err = ST_COLON;
    end

    // Keep the sum reduced: one compare and subtract per character.
    sum      = {1'b0, acc} + {1'b0, term};
    acc_next = acc;
    if (in_range && char_err == ST_OK && is_digit) begin
      if (sum >= {1'b0, DaySeconds}) begin
        acc_next = SecondsWidth'(sum - {1'b0, DaySeconds});
      end else begin
        acc_next = sum[SecondsWidth-1:0];
      end
    end

    error_code_next = error_code;
    if (in_range && error_code == ST_OK) begin
      error_code_next = char_err;
    end

    position_next = (position < PosMax) ? position + 4'd1 : position;

    if (position_next > LenMax) begin
      final_status = ST_LONG;
    end else if (error_code_next != ST_OK) begin
      final_status = error_code_next;
    end else if (position_next == LenHhMm || position_next == LenHhMmSs ||
                 (position_next == LenHh && accept_hours_only)) begin
      final_status = ST_OK;
    end else begin
      final_status = ST_LENGTH;
    end

    result.status  = final_status;
    result.seconds = (final_status == ST_OK) ? acc_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accept_hours_only <= 1'b1;
    end else if (cfg_we) begin
      accept_hours_only <= cfg_wdata;
    end
  end

  // Clear the string state after the last beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      acc        <= '0;
      error_code <= ST_OK;
    end else if (advance) begin
      if (hold_last) begin
        position   <= '0;
        acc        <= '0;
        error_code <= ST_OK;
      end else begin
        position   <= position_next;
        acc        <= acc_next;
        error_code <= error_code_next;
      end
    end
  end

endmodule

/* rtl/core/tss_out_stage.sv */
module tss_out_stage import tss_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  result_t                 result,
  output logic                    room,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [SecondsWidth-1:0] seconds,
  output logic [2:0]              status
);

  // Room when empty or when the held beat leaves this cycle.
  assign room = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      seconds <= result.seconds;
      status  <= 3'(result.status);
    end
  end

endmodule

/* rtl/core/time_string_to_seconds.sv */
// The last character waits in the input register until the result register has room.
// Throughput: one character per cycle unless a last character meets a full, stalled
// result register; the input register and the result register each hold one beat, so
// characters that are not last keep flowing while a finished result waits to be taken.
// Reset (rst, synchronous, active high): clears the position, the running sum, the error
// code and both valid flags, and sets accept_hours_only to 1.
module time_string_to_seconds import tss_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic                    cfg_wdata,
  input  logic                    char_valid,
  output logic                    char_stall,
  input  logic [7:0]              character,
  input  logic                    last,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [SecondsWidth-1:0] seconds,
  output logic [2:0]              status
);

  logic       hold_valid;
  logic [7:0] hold_char;
  logic       hold_last;
  logic       room;
  logic       advance;
  result_t    result;

  // A held character moves on unless it ends the string and the result
  // register is still full and stalled. Characters that are not last never
  // need the result register, so they advance every cycle.
  assign advance = hold_valid && (!hold_last || room);

  // Stage one: register the incoming character beat.
  tss_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .character  (character),
    .last       (last),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_char  (hold_char),
    .hold_last  (hold_last)
  );

  // Per-character checks, the day-reduced running sum, and the final
  // status on the last character. String state updates as the beat advances.
  tss_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .hold_char (hold_char),
    .hold_last (hold_last),
    .result    (result)
  );

  // Stage two: hold the result beat until the sink takes it.
  tss_out_stage u_out_stage (
    .clk          (clk),
    .rst          (rst),
    .load         (advance && hold_last),
    .result       (result),
    .room         (room),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .seconds      (seconds),
    .status       (status)
  );

endmodule
